// File: sv/pba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pba_pkg - shared types and constants of the paged bump allocator
// Request and result payloads, command codes, status codes and the
// controller-to-datapath command and status bundles.
// ----------------------------------------------------------------------------
package pba_pkg;

	localparam int MAX_PAGES = 8;
	localparam int PAGE_W    = $clog2(MAX_PAGES);
	localparam int CNT_W     = $clog2(MAX_PAGES + 1);
	localparam int SIZE_BITS = 25;
	localparam int REQ_W     = 24;
	localparam int ALIGN_W   = 17;

	localparam logic [SIZE_BITS-1:0] MIN_DEFAULT_PAGE = SIZE_BITS'(1024);
	localparam logic [SIZE_BITS-1:0] DEFAULT_PAGE_RST = SIZE_BITS'(65536);

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_CLEAR = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_GRANT   = 2'd0,
		STAT_NULL    = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_CLEARED = 2'd3
	} stat_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [REQ_W-1:0]   req_size;
		logic [ALIGN_W-1:0] align_bytes;
	} req_t;

	typedef struct packed {
		stat_t                status;
		logic [PAGE_W-1:0]    page_index;
		logic [SIZE_BITS-1:0] offset;
		logic                 opened_page;
		logic [SIZE_BITS-1:0] page_capacity_out;
	} res_t;

	// Which result the datapath builds and which state update goes with it
	typedef enum logic [2:0] {
		RES_GRANT = 3'd0,
		RES_OPEN  = 3'd1,
		RES_NULL  = 3'd2,
		RES_FULL  = 3'd3,
		RES_CLEAR = 3'd4
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     idx_clr;
		logic     idx_inc;
		logic     align_en;
		logic     emit;
		res_sel_t sel;
	} ctrl_t;

	typedef struct packed {
		logic is_clear;
		logic size_zero;
		logic fit;
		logic last_page;
		logic none_open;
		logic table_full;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: sv/pba_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pba_datapath - page tables, alignment and fit check of the allocator
// Holds the head and capacity tables, the page count, the default page size
// register, the request being served and the result register.
// ----------------------------------------------------------------------------
module pba_datapath import pba_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire req_t                 req,
	input  wire logic                 cfg_wr,
	input  wire logic [SIZE_BITS-1:0] cfg_data,
	input  wire ctrl_t                ctrl,
	output dp_stat_t                  stat,
	output logic                      done,
	output res_t                      result
);

	req_t                   req_q;
	logic [CNT_W-1:0]       idx_q;
	logic [CNT_W-1:0]       pages_open_q;
	logic [SIZE_BITS:0]     ah_q;
	logic [SIZE_BITS-1:0]   head_q [MAX_PAGES];
	logic [SIZE_BITS-1:0]   cap_q  [MAX_PAGES];
	logic [SIZE_BITS-1:0]   dflt_q;
	res_t                   res_q;
	logic                   done_q;

	logic [PAGE_W-1:0]      idx;
	logic [PAGE_W-1:0]      open_idx;
	logic [SIZE_BITS-1:0]   head_rd;
	logic [SIZE_BITS-1:0]   cap_rd;
	logic [ALIGN_W-1:0]     mask;
	logic [SIZE_BITS:0]     mask_ext;
	logic [SIZE_BITS:0]     ah_d;
	logic [SIZE_BITS+1:0]   end_sum;
	logic [SIZE_BITS:0]     sz_al;
	logic [SIZE_BITS-1:0]   eff_dflt;
	logic [SIZE_BITS:0]     cap_pre;
	logic [SIZE_BITS-1:0]   new_cap;

	assign idx      = idx_q[PAGE_W-1:0];
	assign open_idx = pages_open_q[PAGE_W-1:0];
	assign head_rd  = head_q[idx];
	assign cap_rd   = cap_q[idx];

	// Round the page head up: (head + a - 1) and not (a - 1), no rounding for zero
	assign mask     = (req_q.align_bytes == '0) ? '0 : req_q.align_bytes - ALIGN_W'(1);
	assign mask_ext = (SIZE_BITS+1)'(mask);
	assign ah_d     = ({1'b0, head_rd} + mask_ext) & ~mask_ext;

	// Fit check on the registered aligned head
	assign end_sum  = {1'b0, ah_q} + (SIZE_BITS+2)'(req_q.req_size);

	// Capacity of a new page: max(size + alignment, default raised to at least 1024), saturated
	assign sz_al    = (SIZE_BITS+1)'(req_q.req_size) + (SIZE_BITS+1)'(req_q.align_bytes);
	assign eff_dflt = (dflt_q < MIN_DEFAULT_PAGE) ? MIN_DEFAULT_PAGE : dflt_q;
	assign cap_pre  = (sz_al > {1'b0, eff_dflt}) ? sz_al : {1'b0, eff_dflt};
	assign new_cap  = cap_pre[SIZE_BITS] ? '1 : cap_pre[SIZE_BITS-1:0];

	// Status back to the controller
	always_comb begin
		stat.is_clear   = (req_q.cmd == CMD_CLEAR);
		stat.size_zero  = (req_q.req_size == '0);
		stat.fit        = (end_sum <= {2'b00, cap_rd});
		stat.last_page  = ((idx_q + CNT_W'(1)) == pages_open_q);
		stat.none_open  = (pages_open_q == '0);
		stat.table_full = (pages_open_q == CNT_W'(MAX_PAGES));
	end

	// Hold the request and the default page size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q <= DEFAULT_PAGE_RST;
		end else if (cfg_wr) begin
			dflt_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			req_q <= req;
		end
		if (ctrl.align_en) begin
			ah_q <= ah_d;
		end
	end

	// Advance the page scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctrl.idx_clr) begin
			idx_q <= '0;
		end else if (ctrl.idx_inc) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	// Update heads and the page count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PAGES; i++) begin
				head_q[i] <= '0;
			end
			pages_open_q <= '0;
		end else if (ctrl.emit) begin
			case (ctrl.sel)
				RES_GRANT: begin
					head_q[idx] <= end_sum[SIZE_BITS-1:0];
				end
				RES_OPEN: begin
					head_q[open_idx] <= SIZE_BITS'(req_q.req_size);
					pages_open_q     <= pages_open_q + CNT_W'(1);
				end
				RES_CLEAR: begin
					for (int i = 0; i < MAX_PAGES; i++) begin
						head_q[i] <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Write a capacity when its page opens
	always_ff @(posedge clk) begin
		if (ctrl.emit && (ctrl.sel == RES_OPEN)) begin
			cap_q[open_idx] <= new_cap;
		end
	end

	// Build the result register
	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			res_q.page_index        <= '0;
			res_q.offset            <= '0;
			res_q.opened_page       <= 1'b0;
			res_q.page_capacity_out <= '0;
			case (ctrl.sel)
				RES_GRANT: begin
					res_q.status            <= STAT_GRANT;
					res_q.page_index        <= idx;
					res_q.offset            <= ah_q[SIZE_BITS-1:0];
					res_q.page_capacity_out <= cap_rd;
				end
				RES_OPEN: begin
					res_q.status            <= STAT_GRANT;
					res_q.page_index        <= open_idx;
					res_q.opened_page       <= 1'b1;
					res_q.page_capacity_out <= new_cap;
				end
				RES_NULL:  res_q.status <= STAT_NULL;
				RES_FULL:  res_q.status <= STAT_FULL;
				default:   res_q.status <= STAT_CLEARED;
			endcase
		end
	end

	// Strobe the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.emit;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

// File: sv/pba_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pba_ctrl - sequencer of the paged bump allocator
// Dispatches each request, walks the open pages (align, then check on each)
// and opens a new page when none fits.
// ----------------------------------------------------------------------------
module pba_ctrl import pba_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output logic          busy,
	output ctrl_t         ctrl
);

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_DISPATCH = 5'b00010,
		S_ALIGN    = 5'b00100,
		S_CHECK    = 5'b01000,
		S_OPEN     = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and datapath commands
	always_comb begin
		state_d       = state_q;
		ctrl.load     = 1'b0;
		ctrl.idx_clr  = 1'b0;
		ctrl.idx_inc  = 1'b0;
		ctrl.align_en = 1'b0;
		ctrl.emit     = 1'b0;
		ctrl.sel      = RES_NULL;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctrl.load = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				ctrl.idx_clr = 1'b1;
				if (stat.is_clear) begin
					ctrl.emit = 1'b1;
					ctrl.sel  = RES_CLEAR;
					state_d   = S_IDLE;
				end else if (stat.size_zero) begin
					ctrl.emit = 1'b1;
					ctrl.sel  = RES_NULL;
					state_d   = S_IDLE;
				end else if (stat.none_open) begin
					state_d = S_OPEN;
				end else begin
					state_d = S_ALIGN;
				end
			end
			S_ALIGN: begin
				ctrl.align_en = 1'b1;
				state_d       = S_CHECK;
			end
			S_CHECK: begin
				if (stat.fit) begin
					ctrl.emit = 1'b1;
					ctrl.sel  = RES_GRANT;
					state_d   = S_IDLE;
				end else if (stat.last_page) begin
					state_d = S_OPEN;
				end else begin
					ctrl.idx_inc = 1'b1;
					state_d      = S_ALIGN;
				end
			end
			S_OPEN: begin
				ctrl.emit = 1'b1;
				ctrl.sel  = stat.table_full ? RES_FULL : RES_OPEN;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

// File: sv/paged_bump_allocator_unit.sv
`default_nettype none
// Accept to result strobe: a head clear or a zero size is answered from dispatch; a
// grant follows an align and a check step on each page up to the first that fits; a page
// is opened (or table full reported) after all open pages were checked, or from dispatch if none.
// One request at a time: busy drops as the result strobe rises and the next request
// is taken in that cycle. No receiver stall.
// Reset clears all heads, the page count and the sequencer; default page size 65536.
// ----------------------------------------------------------------------------
// paged_bump_allocator_unit - multi-page scratch allocator
// First-fit bump allocation over up to eight pages with per-request alignment,
// page opening on miss and a clear-all-heads command.
// ----------------------------------------------------------------------------
module paged_bump_allocator_unit import pba_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire req_t                 req,
	output logic                      done,
	output res_t                      result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [SIZE_BITS-1:0] cfg_data
);

	ctrl_t    ctrl;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	pba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	pba_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.ctrl     (ctrl),
		.stat     (stat),
		.done     (done),
		.result   (result)
	);

`ifndef SYNTHESIS
	// A result only closes a request that was in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

	// An accepted request makes the unit busy
	a_busy_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// One result per request, never two in a row
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

	// A newly opened page always starts its grant at offset zero
	a_open_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.opened_page) |-> (result.offset == '0 &&
			result.status == STAT_GRANT))
		else $error("opened page grant not at offset zero");
`endif

endmodule
`default_nettype wire
